// File: rtl/bs33_pkg.sv
package bs33_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
	localparam int CFG_BITS    = 11;
	localparam int SUM_BITS    = 20;
	localparam int POS_BITS    = 10;
	localparam int COL_BITS    = SAMPLE_BITS + 2;
	localparam int PSUM_BITS   = COL_BITS + 1;
	localparam int WIDTH_MIN   = 3;
	localparam int WIDTH_RESET = 4;
	localparam int LINE_BITS   = 2 * SAMPLE_BITS;
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PTR   = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CNT   = $clog2(OFIFO_DEPTH + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COL_BITS-1:0]    col_sum_t;
	typedef logic signed [PSUM_BITS-1:0]   psum_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;
	typedef logic [POS_BITS-1:0]           pos_t;
	typedef logic [ADDR_BITS-1:0]          addr_t;
	typedef logic [CFG_BITS-1:0]           cfg_t;
	typedef logic [LINE_BITS-1:0]          line_t;
	typedef logic [OFIFO_CNT-1:0]          ocnt_t;

	localparam sample_t SAMPLE_EOM = '1;
	localparam pos_t    ROW_MAX    = '1;
	localparam addr_t   ADDR_LAST  = addr_t'(MAX_WIDTH - 1);

	// one accepted sample on its way from the counters to the arithmetic
	typedef struct packed {
		logic    valid;
		logic    eom;
		logic    res;
		pos_t    row;
		pos_t    col;
		addr_t   addr;
		sample_t smp;
	} tok_t;

	typedef struct packed {
		sum_t sum;
		pos_t row;
		pos_t col;
	} result_t;

endpackage

// File: rtl/bs33_ram.sv
module bs33_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/bs33_seq.sv
module bs33_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  bs33_pkg::cfg_t    wr_data,
	input  logic              accept,
	input  bs33_pkg::sample_t sample,
	output bs33_pkg::tok_t    tok,
	output logic              rd_en,
	output bs33_pkg::addr_t   rd_addr,
	output logic              clearing,
	output bs33_pkg::addr_t   clr_addr
);
	import bs33_pkg::*;

	cfg_t    row_width_q;
	cfg_t    w_eff;
	addr_t   last;
	addr_t   col_q;
	pos_t    row_q;
	addr_t   c;
	logic    eom;
	logic    clr_q;
	addr_t   clr_cnt_q;
	logic    valid_s1;
	logic    eom_s1;
	logic    res_s1;
	pos_t    row_s1;
	pos_t    col_s1;
	addr_t   addr_s1;
	sample_t smp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= cfg_t'(WIDTH_RESET);
		end else if (wr_en) begin
			row_width_q <= wr_data;
		end
	end

	always_comb begin
		if (row_width_q < cfg_t'(WIDTH_MIN)) begin
			w_eff = cfg_t'(WIDTH_MIN);
		end else if (row_width_q > cfg_t'(MAX_WIDTH)) begin
			w_eff = cfg_t'(MAX_WIDTH);
		end else begin
			w_eff = row_width_q;
		end
	end

	assign last = addr_t'(w_eff - cfg_t'(1));
	assign c    = (cfg_t'(col_q) >= w_eff) ? last : col_q;
	assign eom  = (sample == SAMPLE_EOM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (eom) begin
				col_q <= '0;
				row_q <= '0;
			end else if (c >= last) begin
				col_q <= '0;
				if (row_q != ROW_MAX) begin
					row_q <= row_q + pos_t'(1);
				end
			end else begin
				col_q <= c + addr_t'(1);
			end
		end
	end

	// zero the line memory, both stored rows, after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + addr_t'(1);
			if (clr_cnt_q == ADDR_LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eom_s1  <= eom;
			res_s1  <= !eom && (row_q >= pos_t'(2)) && (c >= addr_t'(2));
			row_s1  <= row_q - pos_t'(2);
			col_s1  <= pos_t'(c - addr_t'(2));
			addr_s1 <= c;
			smp_s1  <= sample;
		end
	end

	assign tok      = '{valid: valid_s1, eom: eom_s1, res: res_s1, row: row_s1,
		col: col_s1, addr: addr_s1, smp: smp_s1};
	assign rd_en    = accept && !eom;
	assign rd_addr  = c;
	assign clearing = clr_q;
	assign clr_addr = clr_cnt_q;

endmodule

// File: rtl/bs33_calc.sv
module bs33_calc (
	input  logic              clk,
	input  logic              arst_n,
	input  bs33_pkg::tok_t    tok,
	input  bs33_pkg::line_t   rd_data,
	output logic              wb_we,
	output bs33_pkg::addr_t   wb_addr,
	output bs33_pkg::line_t   wb_data,
	output logic              push,
	output bs33_pkg::result_t push_data
);
	import bs33_pkg::*;

	sample_t  upper;
	sample_t  lower;
	col_sum_t col_sum;
	col_sum_t prev_q;
	col_sum_t prev2_q;
	logic     valid_s2;
	col_sum_t col_sum_s2;
	psum_t    psum_s2;
	pos_t     row_s2;
	pos_t     col_s2;

	// stored word: {two rows up, one row up}
	assign upper   = rd_data[LINE_BITS-1:SAMPLE_BITS];
	assign lower   = rd_data[SAMPLE_BITS-1:0];
	assign col_sum = col_sum_t'(upper) + col_sum_t'(lower) + col_sum_t'(tok.smp);

	assign wb_we   = tok.valid && !tok.eom;
	assign wb_addr = tok.addr;
	assign wb_data = {lower, tok.smp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			prev2_q <= '0;
		end else if (tok.valid) begin
			if (tok.eom) begin
				prev_q  <= '0;
				prev2_q <= '0;
			end else begin
				prev2_q <= prev_q;
				prev_q  <= col_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= tok.valid && tok.res;
		end
	end

	always_ff @(posedge clk) begin
		col_sum_s2 <= col_sum;
		psum_s2    <= psum_t'(prev_q) + psum_t'(prev2_q);
		row_s2     <= tok.row;
		col_s2     <= tok.col;
	end

	assign push           = valid_s2;
	assign push_data.sum  = sum_t'(psum_s2) + sum_t'(col_sum_s2);
	assign push_data.row  = row_s2;
	assign push_data.col  = col_s2;

endmodule

// File: rtl/bs33_ofifo.sv
module bs33_ofifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bs33_pkg::result_t push_data,
	input  logic              pop,
	output logic              not_empty,
	output bs33_pkg::result_t head,
	output bs33_pkg::ocnt_t   count
);
	import bs33_pkg::*;

	result_t              mem_q [OFIFO_DEPTH];
	logic [OFIFO_PTR-1:0] wr_ptr_q;
	logic [OFIFO_PTR-1:0] rd_ptr_q;
	ocnt_t                cnt_q;

	localparam logic [OFIFO_PTR-1:0] PTR_LAST = OFIFO_PTR'(OFIFO_DEPTH - 1);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + OFIFO_PTR'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + OFIFO_PTR'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + ocnt_t'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - ocnt_t'(1);
			end
		end
	end

	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign count     = cnt_q;

endmodule

// File: rtl/box_sum_3x3_valid_core.sv
// 3x3 box sum over a row-major sample stream, valid region only. Each window
// result is the sum of nine samples, tagged with the row and column of its
// top-left corner; results appear in raster order for rows >= 2 and columns
// >= 2 of the input. One sample per clock is accepted while the queue has
// room and no clear runs: the two previous rows live in one 1024 x 32 line
// memory read and written once per sample, with the writeback in the cycle
// after the read, so back-to-back samples never touch the same entry. A
// result passes the token and sum registers and the output queue, leaving
// it on out_ready. A sample of -1 ends the matrix and restarts the position
// counters. After reset the 1024 entries are zeroed while in_ready stays
// low; row_width is to be written only while no transaction is in flight.
module box_sum_3x3_valid_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  bs33_pkg::cfg_t    wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  bs33_pkg::sample_t sample,
	output logic              out_valid,
	input  logic              out_ready,
	output bs33_pkg::sum_t    window_sum,
	output bs33_pkg::pos_t    out_row,
	output bs33_pkg::pos_t    out_col
);
	import bs33_pkg::*;

	logic    accept;
	tok_t    tok;
	logic    rd_en;
	addr_t   rd_addr;
	logic    clearing;
	addr_t   clr_addr;
	line_t   rd_data;
	logic    wb_we;
	addr_t   wb_addr;
	line_t   wb_data;
	logic    ram_we;
	addr_t   ram_waddr;
	line_t   ram_wdata;
	logic    push;
	result_t push_data;
	logic    pop;
	result_t head;
	ocnt_t   count;
	logic [OFIFO_CNT:0] committed;

	// queue entries already spoken for by results in flight
	assign committed = {1'b0, count} + (OFIFO_CNT+1)'(tok.valid && tok.res)
		+ (OFIFO_CNT+1)'(push);
	assign in_ready  = !clearing && (committed < (OFIFO_CNT+1)'(OFIFO_DEPTH));
	assign accept    = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	bs33_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.accept   (accept),
		.sample   (sample),
		.tok      (tok),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.clearing (clearing),
		.clr_addr (clr_addr)
	);

	assign ram_we    = clearing || wb_we;
	assign ram_waddr = clearing ? clr_addr : wb_addr;
	assign ram_wdata = clearing ? '0 : wb_data;

	bs33_ram #(
		.WIDTH (LINE_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bs33_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.rd_data   (rd_data),
		.wb_we     (wb_we),
		.wb_addr   (wb_addr),
		.wb_data   (wb_data),
		.push      (push),
		.push_data (push_data)
	);

	bs33_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.not_empty (out_valid),
		.head      (head),
		.count     (count)
	);

	assign window_sum = head.sum;
	assign out_row    = head.row;
	assign out_col    = head.col;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept)
		else $error("transaction accepted during line memory clear");

	a_no_rmw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_we && rd_en) |-> (wb_addr != rd_addr))
		else $error("writeback and read hit the same line entry");

	a_no_fifo_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count == ocnt_t'(OFIFO_DEPTH)) |-> (!push || pop))
		else $error("output queue overflow");

	a_result_follows_token: assert property (@(posedge clk) disable iff (!arst_n)
		(tok.valid && tok.res) |=> push)
		else $error("result lost between stages");

endmodule
